### hw/rtl/triangle_edge_rasterizer_defines.svh
// Assertion helpers for the rasterizer RTL.
`ifndef TRIANGLE_EDGE_RASTERIZER_DEFINES_SVH
`define TRIANGLE_EDGE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TRA_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TRA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

### hw/rtl/tra_pkg.sv
`timescale 1ns / 1ps
package tra_pkg;

  // Fixed widths of the item and result streams, pixel field and color channel count
  localparam int PIX_W       = 11;
  localparam int CHAN_N      = 4;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;

  // Configuration register indexes
  localparam logic [2:0] REG_VERTEX_A = 3'd0;
  localparam logic [2:0] REG_VERTEX_B = 3'd1;
  localparam logic [2:0] REG_VERTEX_C = 3'd2;
  localparam logic [2:0] REG_COLOR_A  = 3'd3;
  localparam logic [2:0] REG_COLOR_B  = 3'd4;
  localparam logic [2:0] REG_COLOR_C  = 3'd5;
  localparam logic [2:0] REG_CULL     = 3'd6;

  // Cull modes
  localparam logic [1:0] CULL_POS = 2'd1;
  localparam logic [1:0] CULL_NEG = 2'd2;

  localparam logic [7:0] COLOR_MAX = 8'd255;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_EDGE,
    FS_PROD,
    FS_AREA
  } front_state_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_MUL,
    BS_NORM,
    BS_DIV,
    BS_OUT
  } back_state_t;

endpackage

### hw/rtl/tra_fifo.sv
`timescale 1ns / 1ps
// Two-entry queue between setup/traversal and shading.
module tra_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  output logic             valid,
  output logic [WIDTH-1:0] data,
  input  logic             pop
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign data  = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/tra_front.sv
`timescale 1ns / 1ps
// Triangle setup and bounding-box traversal; one queue entry per pixel or per culled triangle.
module tra_front #(
  parameter int COORD_BITS = 11,
  parameter int ENTRY_W    = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [31:0]           cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic                  s_restart,
  output logic                  q_push,
  output logic [ENTRY_W-1:0]    q_data,
  input  logic                  q_full
);

  localparam int C  = COORD_BITS;
  localparam int EW = 2 * COORD_BITS + 3;
  localparam int PW = 2 * COORD_BITS + 2;

  tra_pkg::front_state_t state, state_next;

  // Configuration registers
  logic [2*C-1:0] cfg_vtx [3];
  logic [31:0]    cfg_col [3];
  logic [1:0]     cfg_cull;

  // Latched triangle
  logic [C-1:0]   vx [3];
  logic [C-1:0]   vy [3];
  logic [31:0]    lat_col [3];
  logic [1:0]     mode;

  // Setup intermediates
  logic signed [C:0]    dx [3];
  logic signed [C:0]    dy [3];
  logic signed [C:0]    px [3];
  logic signed [C:0]    py [3];
  logic [C-1:0]         min_x, max_x, min_y, max_y;
  logic signed [PW-1:0] pa1, pa2;
  logic signed [PW-1:0] pe1 [3];
  logic signed [PW-1:0] pe2 [3];

  // Walk state
  logic signed [EW-1:0] area;
  logic signed [EW-1:0] row_e [3];
  logic signed [EW-1:0] cur_e [3];
  logic [C-1:0]         cx, cy;
  logic                 walking;

  // Combinational helpers
  logic [C-1:0]         mnx, mxx, mny, mxy;
  logic signed [EW-1:0] area_n;
  logic                 cull_hit;
  logic                 accept;
  logic                 step;
  logic                 cov, end_row, fin;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign step      = accept && !s_restart && walking;

  // Bounding box of the latched vertices
  always_comb begin
    mnx = (vx[0] < vx[1]) ? vx[0] : vx[1];
    mnx = (mnx < vx[2]) ? mnx : vx[2];
    mxx = (vx[0] > vx[1]) ? vx[0] : vx[1];
    mxx = (mxx > vx[2]) ? mxx : vx[2];
    mny = (vy[0] < vy[1]) ? vy[0] : vy[1];
    mny = (mny < vy[2]) ? mny : vy[2];
    mxy = (vy[0] > vy[1]) ? vy[0] : vy[1];
    mxy = (mxy > vy[2]) ? mxy : vy[2];
  end

  // Area and cull test
  always_comb begin
    area_n   = EW'(pa1) - EW'(pa2);
    cull_hit = ((mode == tra_pkg::CULL_POS) && (area_n > 0)) ||
               ((mode == tra_pkg::CULL_NEG) && (area_n < 0));
  end

  // Coverage of the current pixel
  always_comb begin
    cov = ((!cur_e[0][EW-1] && !cur_e[1][EW-1] && !cur_e[2][EW-1]) ||
           (cur_e[0][EW-1] && cur_e[1][EW-1] && cur_e[2][EW-1])) && (area != '0);
    end_row = (cx >= max_x);
    fin     = end_row && (cy >= max_y);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tra_pkg::FS_IDLE: if (accept && s_restart) state_next = tra_pkg::FS_EDGE;
      tra_pkg::FS_EDGE: state_next = tra_pkg::FS_PROD;
      tra_pkg::FS_PROD: state_next = tra_pkg::FS_AREA;
      tra_pkg::FS_AREA: if (!cull_hit || !q_full) state_next = tra_pkg::FS_IDLE;
      default:          state_next = tra_pkg::FS_IDLE;
    endcase
  end

  // Handshake and queue entry
  always_comb begin
    s_tready = (state == tra_pkg::FS_IDLE) && !q_full;
    q_push   = 1'b0;
    q_data   = '0;
    if (state == tra_pkg::FS_AREA && cull_hit && !q_full) begin
      q_push = 1'b1;
      q_data = ENTRY_W'(3'b110);
    end else if (step) begin
      q_push = 1'b1;
      q_data = {lat_col[2], lat_col[1], lat_col[0], area,
                cur_e[2], cur_e[1], cur_e[0], cy, cx, fin, 1'b0, cov};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tra_pkg::FS_IDLE;
    else     state <= state_next;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        cfg_vtx[i] <= '0;
        cfg_col[i] <= '0;
      end
      cfg_cull <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tra_pkg::REG_VERTEX_A: cfg_vtx[0] <= cfg_data[2*C-1:0];
        tra_pkg::REG_VERTEX_B: cfg_vtx[1] <= cfg_data[2*C-1:0];
        tra_pkg::REG_VERTEX_C: cfg_vtx[2] <= cfg_data[2*C-1:0];
        tra_pkg::REG_COLOR_A:  cfg_col[0] <= cfg_data;
        tra_pkg::REG_COLOR_B:  cfg_col[1] <= cfg_data;
        tra_pkg::REG_COLOR_C:  cfg_col[2] <= cfg_data;
        tra_pkg::REG_CULL:     cfg_cull   <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Setup pipeline: latch, edge vectors, products
  always_ff @(posedge clk) begin
    if (accept && s_restart) begin
      for (int i = 0; i < 3; i++) begin
        vx[i]      <= cfg_vtx[i][C-1:0];
        vy[i]      <= cfg_vtx[i][2*C-1:C];
        lat_col[i] <= cfg_col[i];
      end
      mode <= cfg_cull;
    end
    if (state == tra_pkg::FS_EDGE) begin
      for (int i = 0; i < 3; i++) begin
        dx[i] <= $signed({1'b0, vx[(i+1)%3]}) - $signed({1'b0, vx[i]});
        dy[i] <= $signed({1'b0, vy[(i+1)%3]}) - $signed({1'b0, vy[i]});
        px[i] <= $signed({1'b0, mnx}) - $signed({1'b0, vx[i]});
        py[i] <= $signed({1'b0, mny}) - $signed({1'b0, vy[i]});
      end
      min_x <= mnx;
      max_x <= mxx;
      min_y <= mny;
      max_y <= mxy;
    end
    if (state == tra_pkg::FS_PROD) begin
      pa1 <= dx[1] * dy[0];
      pa2 <= dy[1] * dx[0];
      for (int i = 0; i < 3; i++) begin
        pe1[i] <= px[i] * dy[i];
        pe2[i] <= py[i] * dx[i];
      end
    end
  end

  // Edge walk
  always_ff @(posedge clk) begin
    if (rst) begin
      walking <= 1'b0;
      area    <= '0;
      cx      <= '0;
      cy      <= '0;
      for (int i = 0; i < 3; i++) begin
        row_e[i] <= '0;
        cur_e[i] <= '0;
      end
    end else begin
      if (accept && s_restart) begin
        walking <= 1'b0;
      end else if (state == tra_pkg::FS_AREA && !cull_hit) begin
        walking <= 1'b1;
        area    <= area_n;
        cx      <= min_x;
        cy      <= min_y;
        for (int i = 0; i < 3; i++) begin
          row_e[i] <= EW'(pe1[i]) - EW'(pe2[i]);
          cur_e[i] <= EW'(pe1[i]) - EW'(pe2[i]);
        end
      end else if (state == tra_pkg::FS_AREA && !q_full) begin
        area <= area_n;
      end else if (step) begin
        if (fin) begin
          walking <= 1'b0;
        end else if (end_row) begin
          cy <= cy + 1'b1;
          cx <= min_x;
          for (int i = 0; i < 3; i++) begin
            row_e[i] <= row_e[i] - EW'(dx[i]);
            cur_e[i] <= row_e[i] - EW'(dx[i]);
          end
        end else begin
          cx <= cx + 1'b1;
          for (int i = 0; i < 3; i++) begin
            cur_e[i] <= cur_e[i] + EW'(dy[i]);
          end
        end
      end
    end
  end

endmodule

### hw/rtl/tra_back.sv
`timescale 1ns / 1ps
`include "triangle_edge_rasterizer_defines.svh"
// Gouraud shading: weighted color sums and a bit-per-cycle divide, four lanes.
module tra_back #(
  parameter int COORD_BITS = 11,
  parameter int ENTRY_W    = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  logic [ENTRY_W-1:0]    q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic                  out_cov,
  output logic                  out_culled,
  output logic                  out_last,
  output logic [31:0]           out_color
);

  localparam int C   = COORD_BITS;
  localparam int EW  = 2 * COORD_BITS + 3;
  localparam int NW  = EW + 10;
  localparam int OFE = 3 + 2 * COORD_BITS;
  localparam int OFC = OFE + 4 * EW;
  localparam int CH  = tra_pkg::CHAN_N;

  tra_pkg::back_state_t state, state_next;

  // Latched entry
  logic [C-1:0]         x_r, y_r;
  logic                 cov_r, culled_r, last_r;
  logic signed [EW-1:0] e_r [3];
  logic signed [EW-1:0] area_r;
  logic [31:0]          col_r [3];

  // Lane state
  logic [1:0]           term;
  logic [3:0]           cnt;
  logic signed [NW-1:0] acc [CH];
  logic signed [NW-1:0] rem [CH];
  logic [8:0]           quo [CH];
  logic                 neg [CH];
  logic signed [NW-1:0] den_sh;

  // Combinational helpers
  logic signed [EW-1:0] e_sel;
  logic [31:0]          c_sel;
  logic signed [EW+8:0] prod [CH];
  logic signed [NW-1:0] trial [CH];
  logic signed [EW-1:0] area_abs;

  // Term select: e1*cA, e2*cB, e0*cC
  always_comb begin
    unique case (term)
      2'd0:    begin e_sel = e_r[1]; c_sel = col_r[0]; end
      2'd1:    begin e_sel = e_r[2]; c_sel = col_r[1]; end
      default: begin e_sel = e_r[0]; c_sel = col_r[2]; end
    endcase
    for (int k = 0; k < CH; k++) begin
      prod[k]  = e_sel * $signed({1'b0, c_sel[8*k +: 8]});
      trial[k] = rem[k] - den_sh;
    end
    area_abs = area_r[EW-1] ? -area_r : area_r;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tra_pkg::BS_IDLE: if (q_valid) begin
        state_next = q_data[0] ? tra_pkg::BS_MUL : tra_pkg::BS_OUT;
      end
      tra_pkg::BS_MUL:  if (term == 2'd2) state_next = tra_pkg::BS_NORM;
      tra_pkg::BS_NORM: state_next = tra_pkg::BS_DIV;
      tra_pkg::BS_DIV:  if (cnt == 4'd0) state_next = tra_pkg::BS_OUT;
      tra_pkg::BS_OUT:  if (out_ready) state_next = tra_pkg::BS_IDLE;
      default:          state_next = tra_pkg::BS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    q_pop      = (state == tra_pkg::BS_IDLE) && q_valid;
    out_valid  = (state == tra_pkg::BS_OUT);
    out_x      = x_r;
    out_y      = y_r;
    out_cov    = cov_r;
    out_culled = culled_r;
    out_last   = last_r;
    for (int k = 0; k < CH; k++) begin
      if (neg[k])      out_color[8*k +: 8] = '0;
      else if (quo[k][8]) out_color[8*k +: 8] = tra_pkg::COLOR_MAX;
      else             out_color[8*k +: 8] = quo[k][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tra_pkg::BS_IDLE;
    else     state <= state_next;
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      tra_pkg::BS_IDLE: begin
        if (q_valid) begin
          cov_r    <= q_data[0];
          culled_r <= q_data[1];
          last_r   <= q_data[2];
          x_r      <= q_data[3 +: C];
          y_r      <= q_data[3+C +: C];
          for (int i = 0; i < 3; i++) begin
            e_r[i]   <= q_data[OFE + EW*i +: EW];
            col_r[i] <= q_data[OFC + 32*i +: 32];
          end
          area_r <= q_data[OFE + 3*EW +: EW];
          term   <= 2'd0;
          for (int k = 0; k < CH; k++) begin
            acc[k] <= '0;
            quo[k] <= '0;
            neg[k] <= 1'b0;
          end
        end
      end
      tra_pkg::BS_MUL: begin
        term <= term + 2'd1;
        for (int k = 0; k < CH; k++) begin
          acc[k] <= acc[k] + NW'(prod[k]);
        end
      end
      tra_pkg::BS_NORM: begin
        den_sh <= NW'(area_abs) <<< 8;
        cnt    <= 4'd8;
        for (int k = 0; k < CH; k++) begin
          if (area_r[EW-1]) begin
            rem[k] <= -acc[k];
            neg[k] <= (acc[k] > 0);
          end else begin
            rem[k] <= acc[k];
            neg[k] <= acc[k][NW-1];
          end
        end
      end
      tra_pkg::BS_DIV: begin
        cnt    <= cnt - 4'd1;
        den_sh <= den_sh >>> 1;
        for (int k = 0; k < CH; k++) begin
          quo[k] <= {quo[k][7:0], !trial[k][NW-1]};
          if (!trial[k][NW-1]) rem[k] <= trial[k];
        end
      end
      default: ;
    endcase
  end

  `TRA_ASSERT_IMPL(a_cull_last, out_valid && out_culled, out_last, "culled result lacks last")
  `TRA_ASSERT_IMPL(a_uncov_dark, out_valid && !out_cov, out_color == '0, "uncovered pixel colored")
  `TRA_ASSERT_NEXT(a_pop_busy, q_pop, state != tra_pkg::BS_IDLE, "entry popped but not taken")

endmodule

### hw/rtl/triangle_edge_rasterizer.sv
`timescale 1ns / 1ps
// Channel   Signals                          Transaction
// s_        s_tvalid s_tready s_tdata        one item: restart or advance
// m_        m_tvalid m_tready m_tdata ...    one pixel or cull result
// cfg_      cfg_valid cfg_ready cfg_index .. one register write
//
// Restart: setup runs edge vectors, products and area before the next item.
// Advance: accepted while setup is idle and the 2-entry queue has room.
// Shading: an uncovered or culled result goes from load straight to out; a covered
// pixel runs load, weighted sums, sign fix, divide and out, in that order.
// Reset clears the state machines, queue, configuration and walk state; either side may stall freely.
module triangle_edge_rasterizer #(
  parameter int COORD_BITS = 11
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [2:0]                          cfg_index,
  input  logic [31:0]                         cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // bit 0 restart, rest zero
  input  logic [tra_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // pixel_x, pixel_y, covered, red, green, blue, alpha, one zero bit
  output logic [tra_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // culled
  output logic                                m_tuser,
  output logic                                m_tlast
);

  localparam int EW      = 2 * COORD_BITS + 3;
  localparam int ENTRY_W = 3 + 2 * COORD_BITS + 4 * EW + 96;

  logic               q_push, q_full, q_valid, q_pop;
  logic [ENTRY_W-1:0] q_in, q_out;
  logic [COORD_BITS-1:0] ox, oy;
  logic               ocov;
  logic [31:0]        ocolor;

  tra_front #(.COORD_BITS(COORD_BITS), .ENTRY_W(ENTRY_W)) u_front (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_restart(s_tdata[0]),
    .q_push, .q_data(q_in), .q_full
  );

  tra_fifo #(.WIDTH(ENTRY_W)) u_fifo (
    .clk, .rst, .push(q_push), .push_data(q_in), .full(q_full),
    .valid(q_valid), .data(q_out), .pop(q_pop)
  );

  tra_back #(.COORD_BITS(COORD_BITS), .ENTRY_W(ENTRY_W)) u_back (
    .clk, .rst, .q_valid, .q_data(q_out), .q_pop,
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_x(ox), .out_y(oy), .out_cov(ocov), .out_culled(m_tuser),
    .out_last(m_tlast), .out_color(ocolor)
  );

  assign m_tdata = {1'b0, ocolor, ocov, tra_pkg::PIX_W'(oy), tra_pkg::PIX_W'(ox)};

endmodule

### dv/raster_pixel_checker.sv
`timescale 1ns / 1ps
// Watches the config, item and pixel channels, predicts every pixel or cull
// transaction and compares it field by field with what the block produces.
module raster_pixel_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [tra_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [tra_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic        m_tuser,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending,
  output int          predicted
);

  typedef struct packed {
    logic [10:0] px;
    logic [10:0] py;
    logic        covered;
    logic        culled;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last;
  } pixel_t;

  pixel_t pixel_queue[$];

  // Register copies
  logic [21:0] vtx[3];
  logic [31:0] col[3];
  logic [1:0]  cull;

  // Walk state
  longint edge_x[3], edge_y[3], row_e[3], cur_e[3], area;
  longint box_x0, box_x1, box_y0, box_y1, walk_x, walk_y;
  logic [31:0] lat_col[3];
  bit walking;

  function automatic logic [7:0] shade_channel(int ch);
    longint ca, cb, cc, num, den, q;
    ca = (lat_col[0] >> (8 * ch)) & 8'hFF;
    cb = (lat_col[1] >> (8 * ch)) & 8'hFF;
    cc = (lat_col[2] >> (8 * ch)) & 8'hFF;
    num = cur_e[1] * ca + cur_e[2] * cb + cur_e[0] * cc;
    den = area;
    if (den == 0) return 8'd0;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num < 0) return 8'd0;
    q = num / den;
    return (q > 255) ? tra_pkg::COLOR_MAX : q[7:0];
  endfunction

  task automatic check_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // Append one expected transaction
  task automatic queue_pixel(pixel_t p);
    pixel_queue.insert(pixel_queue.size(), p);
    predicted++;
  endtask

  // Start of a triangle: latch vertices and colors, edges and area, then queue a cull result or set up the box
  task automatic start_triangle();
    longint x[3], y[3];
    pixel_t p;
    int n;
    for (int i = 0; i < 3; i++) begin
      x[i] = vtx[i][10:0];
      y[i] = vtx[i][21:11];
      lat_col[i] = col[i];
    end
    for (int i = 0; i < 3; i++) begin
      n = (i + 1) % 3;
      edge_x[i] = x[n] - x[i];
      edge_y[i] = y[n] - y[i];
    end
    area = edge_x[1] * edge_y[0] - edge_y[1] * edge_x[0];
    walking = 0;
    if ((area > 0 && cull == tra_pkg::CULL_POS) || (area < 0 && cull == tra_pkg::CULL_NEG)) begin
      p = '0;
      p.culled = 1;
      p.last = 1;
      queue_pixel(p);
      return;
    end
    box_x0 = x[0]; box_x1 = x[0]; box_y0 = y[0]; box_y1 = y[0];
    for (int i = 1; i < 3; i++) begin
      if (x[i] < box_x0) box_x0 = x[i];
      if (x[i] > box_x1) box_x1 = x[i];
      if (y[i] < box_y0) box_y0 = y[i];
      if (y[i] > box_y1) box_y1 = y[i];
    end
    for (int i = 0; i < 3; i++) begin
      row_e[i] = (box_x0 - x[i]) * edge_y[i] - (box_y0 - y[i]) * edge_x[i];
      cur_e[i] = row_e[i];
    end
    walk_x = box_x0;
    walk_y = box_y0;
    walking = 1;
  endtask

  // One box pixel, then step the edge values
  task automatic next_pixel();
    pixel_t p;
    bit all_pos, all_neg, end_row;
    all_pos = cur_e[0] >= 0 && cur_e[1] >= 0 && cur_e[2] >= 0;
    all_neg = cur_e[0] < 0 && cur_e[1] < 0 && cur_e[2] < 0;
    end_row = walk_x >= box_x1;
    p = '0;
    p.px = walk_x[10:0];
    p.py = walk_y[10:0];
    p.covered = (all_pos || all_neg) && area != 0;
    if (p.covered) begin
      p.red   = shade_channel(0);
      p.green = shade_channel(1);
      p.blue  = shade_channel(2);
      p.alpha = shade_channel(3);
    end
    p.last = end_row && walk_y >= box_y1;
    queue_pixel(p);
    if (p.last) begin
      walking = 0;
    end else if (end_row) begin
      walk_y++;
      walk_x = box_x0;
      for (int i = 0; i < 3; i++) begin
        row_e[i] -= edge_x[i];
        cur_e[i] = row_e[i];
      end
    end else begin
      walk_x++;
      for (int i = 0; i < 3; i++) cur_e[i] += edge_y[i];
    end
  endtask

  always @(posedge clk) begin
    pixel_t exp_p;
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        vtx[i] = '0;
        col[i] = '0;
        lat_col[i] = '0;
        edge_x[i] = 0; edge_y[i] = 0; row_e[i] = 0; cur_e[i] = 0;
      end
      cull = '0;
      area = 0;
      walking = 0;
      pixel_queue.delete();
    end else begin
      // Register write transaction
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tra_pkg::REG_VERTEX_A: vtx[0] = cfg_data[21:0];
          tra_pkg::REG_VERTEX_B: vtx[1] = cfg_data[21:0];
          tra_pkg::REG_VERTEX_C: vtx[2] = cfg_data[21:0];
          tra_pkg::REG_COLOR_A:  col[0] = cfg_data;
          tra_pkg::REG_COLOR_B:  col[1] = cfg_data;
          tra_pkg::REG_COLOR_C:  col[2] = cfg_data;
          tra_pkg::REG_CULL:     cull = cfg_data[1:0];
          default: ;
        endcase
      end
      // Item transaction
      if (s_tvalid && s_tready) begin
        if (s_tdata[0]) start_triangle();
        else if (walking) next_pixel();
      end
      // Result transaction
      if (m_tvalid && m_tready) begin
        if (pixel_queue.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
          fail_count++;
        end else begin
          exp_p = pixel_queue.pop_front();
          check_field("pixel_x", exp_p.px, m_tdata[10:0]);
          check_field("pixel_y", exp_p.py, m_tdata[21:11]);
          check_field("covered", exp_p.covered, m_tdata[22]);
          check_field("red", exp_p.red, m_tdata[30:23]);
          check_field("green", exp_p.green, m_tdata[38:31]);
          check_field("blue", exp_p.blue, m_tdata[46:39]);
          check_field("alpha", exp_p.alpha, m_tdata[54:47]);
          check_field("culled", exp_p.culled, m_tuser);
          check_field("last", exp_p.last, m_tlast);
        end
      end
    end
    pending = pixel_queue.size();
  end

  initial begin
    fail_count = 0;
    predicted = 0;
    pending = 0;
  end
endmodule

### dv/triangle_edge_rasterizer_tb.sv
`timescale 1ns / 1ps
module triangle_edge_rasterizer_tb;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [tra_pkg::IN_TDATA_W-1:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [tra_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  int          fail_count, pending, predicted;
  int          sent;
  bit          quiet;

  triangle_edge_rasterizer dut (.*);

  raster_pixel_checker checker_i (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Result side backpressure
  always @(posedge clk) begin
    m_tready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 35);
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 35) begin
        cfg_valid <= 1'b0;
        @(posedge clk);
      end
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic send_item(bit restart);
    if (!quiet) begin
      while ($urandom_range(0, 99) < 35) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(tra_pkg::IN_TDATA_W - 1){1'b0}}, restart};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // Hold off until every result is in, then let the pipeline drain
  task automatic drain();
    s_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Program one triangle, start it and advance through (part of) its box
  task automatic run_triangle(logic [21:0] va, logic [21:0] vb, logic [21:0] vc,
                              logic [31:0] ca, logic [31:0] cb, logic [31:0] cc,
                              logic [1:0] mode, int extra, int cut);
    int xmin, xmax, ymin, ymax, n;
    write_reg(tra_pkg::REG_VERTEX_A, va);
    write_reg(tra_pkg::REG_VERTEX_B, vb);
    write_reg(tra_pkg::REG_VERTEX_C, vc);
    write_reg(tra_pkg::REG_COLOR_A, ca);
    write_reg(tra_pkg::REG_COLOR_B, cb);
    write_reg(tra_pkg::REG_COLOR_C, cc);
    write_reg(tra_pkg::REG_CULL, {30'd0, mode});
    cfg_valid <= 1'b0;
    xmin = va[10:0]; xmax = xmin; ymin = va[21:11]; ymax = ymin;
    for (int i = 0; i < 2; i++) begin
      int x, y;
      x = (i == 0) ? vb[10:0] : vc[10:0];
      y = (i == 0) ? vb[21:11] : vc[21:11];
      if (x < xmin) xmin = x;
      if (x > xmax) xmax = x;
      if (y < ymin) ymin = y;
      if (y > ymax) ymax = y;
    end
    n = (xmax - xmin + 1) * (ymax - ymin + 1) + extra;
    send_item(1'b1);
    for (int i = 0; i < n; i++) begin
      // a restart part way re-arms the walk from the corner
      send_item(i == cut);
    end
    drain();
  endtask

  function automatic logic [21:0] rand_vertex(int bx, int by);
    return {11'(by + $urandom_range(0, 15)), 11'(bx + $urandom_range(0, 15))};
  endfunction

  initial begin
    int bx, by, mode;
    rst <= 1'b1;
    quiet = 0;
    sent = 0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Advance while idle, then the reset triangle: zero area, one pixel
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
    send_item(1'b0);
    drain();

    // Corners of the coordinate range, both windings, every cull mode
    run_triangle({11'd2047, 11'd2047}, {11'd2047, 11'd2040}, {11'd2040, 11'd2047},
                 32'hFFFF_FFFF, 32'h0000_0000, 32'hFF00_FF00, tra_pkg::CULL_POS, 0, -1);
    run_triangle({11'd2047, 11'd2047}, {11'd2040, 11'd2047}, {11'd2047, 11'd2040},
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd0, 2, -1);
    run_triangle({11'd0, 11'd0}, {11'd0, 11'd6}, {11'd6, 11'd0},
                 32'h00FF_00FF, 32'h1234_5678, 32'h0000_0000, tra_pkg::CULL_NEG, 0, -1);
    run_triangle({11'd0, 11'd0}, {11'd6, 11'd0}, {11'd0, 11'd6},
                 32'h8080_8080, 32'h7F7F_7F7F, 32'hFFFF_FFFF, 2'd3, 0, 4);
    // Collinear: zero area, box walked, nothing covered
    run_triangle({11'd3, 11'd1}, {11'd5, 11'd3}, {11'd7, 11'd5},
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, tra_pkg::CULL_POS, 0, -1);

    // Random triangles until enough items have been sent
    while (sent < 1200) begin
      quiet = (predicted > 500 && predicted < 700);
      case ($urandom_range(0, 4))
        0: begin bx = 0; by = 2032; end
        1: begin bx = 2032; by = 0; end
        default: begin bx = $urandom_range(0, 2032); by = $urandom_range(0, 2032); end
      endcase
      mode = $urandom_range(0, 3);
      run_triangle(rand_vertex(bx, by), rand_vertex(bx, by), rand_vertex(bx, by),
                   $urandom(), $urandom(), $urandom(), mode[1:0],
                   $urandom_range(0, 3),
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30) : -1);
    end

    if (fail_count == 0 && pending == 0) begin
      $display("PASS triangle_edge_rasterizer");
    end else begin
      $display("FAIL triangle_edge_rasterizer");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL triangle_edge_rasterizer");
    $finish;
  end
endmodule
